### src/cbrf_pkg.sv
`timescale 1ns / 1ps
package cbrf_pkg;

	// number format and search limits
	localparam int FRAC_BITS      = 16;
	localparam int MAX_ITERATIONS = 32;
	localparam int COEF_WIDTH     = 16;
	localparam int POINT_W        = 24;
	localparam int TOL_W          = 24;
	localparam int OUTCOME_W      = 2;
	localparam int STEPS_OUT_W    = 6;
	localparam int STEP_W         = $clog2(MAX_ITERATIONS + 1);

	localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(655);
	localparam logic [STEP_W-1:0] MAX_ITER_CNT = STEP_W'(MAX_ITERATIONS);
	localparam logic [STEPS_OUT_W-1:0] MAX_ITER_OUT = STEPS_OUT_W'(MAX_ITERATIONS);

	// accumulator and split multiplier widths
	localparam int ACC_W    = 64;
	localparam int MAG_W    = ACC_W - 1;
	localparam int LO_W     = 32;
	localparam int HI_W     = MAG_W - LO_W;
	localparam int PPLO_W   = LO_W + POINT_W;
	localparam int PPHI_W   = HI_W + POINT_W;
	localparam int PROD_W   = MAG_W + POINT_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (COEF_WIDTH > TOL_W) ? COEF_WIDTH : TOL_W;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CONSTANT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;

	// result status codes
	localparam logic [OUTCOME_W-1:0] OUT_CONVERGED = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_EXACT     = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_NO_ROOT   = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_LIMIT     = 2'd3;

	// datapath operations
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_MAG   = 3'd1;
	localparam logic [2:0] OP_MLO   = 3'd2;
	localparam logic [2:0] OP_MHI   = 3'd3;
	localparam logic [2:0] OP_COMB  = 3'd4;
	localparam logic [2:0] OP_SHIFT = 3'd5;
	localparam logic [2:0] OP_ADD   = 3'd6;
	localparam logic [2:0] OP_INIT  = 3'd7;

	// evaluation point
	localparam logic [1:0] PT_START  = 2'd0;
	localparam logic [1:0] PT_FINISH = 2'd1;
	localparam logic [1:0] PT_MID    = 2'd2;

	// Horner stage coefficient
	localparam logic [1:0] HOR_SQUARE = 2'd0;
	localparam logic [1:0] HOR_LINEAR = 2'd1;
	localparam logic [1:0] HOR_CONST  = 2'd2;

	// root source
	localparam logic [1:0] RS_ZERO   = 2'd0;
	localparam logic [1:0] RS_START  = 2'd1;
	localparam logic [1:0] RS_FINISH = 2'd2;
	localparam logic [1:0] RS_MID    = 2'd3;

	typedef struct packed {
		logic                 load;
		logic [2:0]           op;
		logic [1:0]           pt;
		logic [1:0]           coef;
		logic                 store;
		logic                 mid_en;
		logic                 update;
		logic                 res_load;
		logic [1:0]           res_sel;
		logic [OUTCOME_W-1:0] res_outcome;
		logic [STEP_W-1:0]    steps;
	} cmd_t;

	typedef struct packed {
		logic fs_zero;
		logic ff_zero;
		logic fm_zero;
		logic same_sign;
		logic narrow;
		logic out_free;
	} status_t;

endpackage

### src/cbrf_ctrl.sv
`timescale 1ns / 1ps
module cbrf_ctrl
	import cbrf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_INIT   = 4'd1;
	localparam logic [3:0] ST_EVAL   = 4'd2;
	localparam logic [3:0] ST_STORE  = 4'd3;
	localparam logic [3:0] ST_SIGN   = 4'd4;
	localparam logic [3:0] ST_STEP   = 4'd5;
	localparam logic [3:0] ST_TEST   = 4'd6;
	localparam logic [3:0] ST_UPDATE = 4'd7;
	localparam logic [3:0] ST_CHECK  = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0]           state_q, state_d;
	logic [2:0]           op_q, op_d;
	logic [1:0]           hor_q, hor_d;
	logic [1:0]           pt_q, pt_d;
	logic [STEP_W-1:0]    steps_q, steps_d;
	logic [OUTCOME_W-1:0] outcome_q, outcome_d;
	logic [1:0]           rsel_q, rsel_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		hor_d     = hor_q;
		pt_d      = pt_q;
		steps_d   = steps_q;
		outcome_d = outcome_q;
		rsel_d    = rsel_q;

		cmd             = '0;
		cmd.pt          = pt_q;
		cmd.coef        = hor_q;
		cmd.steps       = steps_q;
		cmd.res_sel     = rsel_q;
		cmd.res_outcome = outcome_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pt_d     = PT_START;
					steps_d  = '0;
					state_d  = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.op  = OP_INIT;
				op_d    = OP_MAG;
				hor_d   = HOR_SQUARE;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.op = op_q;
				unique case (op_q)
					OP_MAG:   op_d = OP_MLO;
					OP_MLO:   op_d = OP_MHI;
					OP_MHI:   op_d = OP_COMB;
					OP_COMB:  op_d = OP_SHIFT;
					OP_SHIFT: op_d = OP_ADD;
					OP_ADD: begin
						op_d = OP_MAG;
						if (hor_q == HOR_CONST) begin
							state_d = ST_STORE;
						end else begin
							hor_d = hor_q + 2'd1;
						end
					end
					default: op_d = OP_MAG;
				endcase
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				unique case (pt_q)
					PT_START: begin
						pt_d    = PT_FINISH;
						state_d = ST_INIT;
					end
					PT_FINISH: state_d = ST_SIGN;
					default:   state_d = ST_TEST;
				endcase
			end
			ST_SIGN: begin
				if (st.same_sign) begin
					outcome_d = OUT_NO_ROOT;
					rsel_d    = RS_ZERO;
					state_d   = ST_DONE;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (steps_q >= MAX_ITER_CNT) begin
					outcome_d = OUT_LIMIT;
					rsel_d    = RS_MID;
					state_d   = ST_DONE;
				end else begin
					cmd.mid_en = 1'b1;
					steps_d    = steps_q + STEP_W'(1);
					pt_d       = PT_MID;
					state_d    = ST_INIT;
				end
			end
			ST_TEST: begin
				priority if (st.fs_zero) begin
					outcome_d = OUT_EXACT;
					rsel_d    = RS_START;
					state_d   = ST_DONE;
				end else if (st.ff_zero) begin
					outcome_d = OUT_EXACT;
					rsel_d    = RS_FINISH;
					state_d   = ST_DONE;
				end else if (st.fm_zero) begin
					outcome_d = OUT_EXACT;
					rsel_d    = RS_MID;
					state_d   = ST_DONE;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.narrow) begin
					outcome_d = OUT_CONVERGED;
					rsel_d    = RS_MID;
					state_d   = ST_DONE;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_DONE: begin
				// wait for the output register to drain
				if (st.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_MAG;
			hor_q     <= HOR_SQUARE;
			pt_q      <= PT_START;
			steps_q   <= '0;
			outcome_q <= OUT_CONVERGED;
			rsel_q    <= RS_ZERO;
		end else begin
			state_q   <= state_d;
			op_q      <= op_d;
			hor_q     <= hor_d;
			pt_q      <= pt_d;
			steps_q   <= steps_d;
			outcome_q <= outcome_d;
			rsel_q    <= rsel_d;
		end
	end

endmodule

### src/cbrf_dp.sv
`timescale 1ns / 1ps
module cbrf_dp
	import cbrf_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output status_t                     st,
	input  logic signed [POINT_W-1:0]   interval_start,
	input  logic signed [POINT_W-1:0]   interval_finish,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [POINT_W-1:0]   root_point,
	output logic [OUTCOME_W-1:0]        outcome,
	output logic [STEPS_OUT_W-1:0]      steps_taken,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam logic signed [ACC_W:0] SUM_MAX = {2'b00, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W:0] SUM_MIN = {2'b11, {(ACC_W-2){1'b0}}, 1'b1};
	localparam logic [MAG_W-1:0]      SAT_MAG = {MAG_W{1'b1}};

	function automatic logic signed [ACC_W-1:0] coef_scaled(logic [COEF_WIDTH-1:0] c);
		logic signed [ACC_W-1:0] e;
		e = {{(ACC_W-COEF_WIDTH){c[COEF_WIDTH-1]}}, c};
		return e <<< FRAC_BITS;
	endfunction

	// configuration
	logic [COEF_WIDTH-1:0] coef_cubic_q, coef_square_q, coef_linear_q, coef_constant_q;
	logic [TOL_W-1:0]      tol_q;

	// search state
	logic signed [POINT_W-1:0] s_q, f_q, mid_q;
	logic signed [ACC_W-1:0]   fs_q, ff_q, fm_q;

	// Horner datapath
	logic signed [ACC_W-1:0] acc_q, prod_q;
	logic [POINT_W-1:0]      xmag_q;
	logic                    xneg_q, pneg_q;
	logic [MAG_W-1:0]        amag_q, pmag_q;
	logic [PPLO_W-1:0]       pplo_q;
	logic [PPHI_W-1:0]       pphi_q;

	logic signed [POINT_W-1:0] x_sel;
	logic [POINT_W-1:0]        x_neg;
	logic [ACC_W-1:0]          acc_neg;
	logic [LO_W-1:0]           mul_a;
	logic [PPLO_W-1:0]         mul_p;
	logic [PROD_W-1:0]         full_prod;
	logic [ACC_W-1:0]          pos_ext, neg_ext;
	logic signed [ACC_W-1:0]   shift_d;
	logic [COEF_WIDTH-1:0]     k_sel;
	logic signed [ACC_W-1:0]   k_scaled;
	logic signed [ACC_W:0]     sum_wide;
	logic signed [ACC_W-1:0]   add_d;
	logic signed [POINT_W:0]   pt_sum, width;
	logic signed [POINT_W-1:0] mid_d;
	logic signed [POINT_W-1:0] root_d;
	logic [STEPS_OUT_W+STEP_W-1:0] steps_ext;
	logic                      out_valid_q;
	logic                      fs_fm_differ;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_cubic_q    <= '0;
			coef_square_q   <= '0;
			coef_linear_q   <= '0;
			coef_constant_q <= '0;
			tol_q           <= TOL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COEF_CUBIC:    coef_cubic_q    <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_SQUARE:   coef_square_q   <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_LINEAR:   coef_linear_q   <= cfg_data[COEF_WIDTH-1:0];
				REG_COEF_CONSTANT: coef_constant_q <= cfg_data[COEF_WIDTH-1:0];
				REG_TOLERANCE:     tol_q           <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.pt)
			PT_START:  x_sel = s_q;
			PT_FINISH: x_sel = f_q;
			default:   x_sel = mid_q;
		endcase
	end
	assign x_neg   = ~x_sel + POINT_W'(1);
	assign acc_neg = ~acc_q + ACC_W'(1);

	// one multiplier, low half of the magnitude first, then the high half
	assign mul_a = (cmd.op == OP_MHI) ? {{(LO_W-HI_W){1'b0}}, amag_q[MAG_W-1:LO_W]}
	                                  : amag_q[LO_W-1:0];
	assign mul_p = mul_a * xmag_q;

	assign full_prod = {pphi_q, {LO_W{1'b0}}} + {{(PROD_W-PPLO_W){1'b0}}, pplo_q};

	// floor of a negative product: shift the negated magnitude arithmetically
	assign pos_ext = {1'b0, pmag_q};
	assign neg_ext = ~pos_ext + ACC_W'(1);
	assign shift_d = pneg_q ? ($signed(neg_ext) >>> FRAC_BITS)
	                        : $signed(pos_ext >> FRAC_BITS);

	always_comb begin
		unique case (cmd.coef)
			HOR_SQUARE: k_sel = coef_square_q;
			HOR_LINEAR: k_sel = coef_linear_q;
			default:    k_sel = coef_constant_q;
		endcase
	end
	assign k_scaled = coef_scaled(k_sel);
	assign sum_wide = {prod_q[ACC_W-1], prod_q} + {k_scaled[ACC_W-1], k_scaled};

	always_comb begin
		priority if (sum_wide > SUM_MAX) begin
			add_d = SUM_MAX[ACC_W-1:0];
		end else if (sum_wide < SUM_MIN) begin
			add_d = SUM_MIN[ACC_W-1:0];
		end else begin
			add_d = sum_wide[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_INIT: begin
				acc_q  <= coef_scaled(coef_cubic_q);
				xneg_q <= x_sel[POINT_W-1];
				xmag_q <= x_sel[POINT_W-1] ? x_neg : x_sel;
			end
			OP_MAG: begin
				amag_q <= acc_q[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
				pneg_q <= acc_q[ACC_W-1] ^ xneg_q;
			end
			OP_MLO:   pplo_q <= mul_p;
			OP_MHI:   pphi_q <= mul_p[PPHI_W-1:0];
			OP_COMB:  pmag_q <= (|full_prod[PROD_W-1:MAG_W]) ? SAT_MAG : full_prod[MAG_W-1:0];
			OP_SHIFT: prod_q <= shift_d;
			OP_ADD:   acc_q  <= add_d;
			default: ;
		endcase
	end

	assign pt_sum = {s_q[POINT_W-1], s_q} + {f_q[POINT_W-1], f_q};
	assign mid_d  = pt_sum[POINT_W:1];
	assign width  = {f_q[POINT_W-1], f_q} - {s_q[POINT_W-1], s_q};
	assign fs_fm_differ = fs_q[ACC_W-1] != fm_q[ACC_W-1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q <= interval_start;
			f_q <= interval_finish;
		end
		if (cmd.mid_en) begin
			mid_q <= mid_d;
		end
		if (cmd.store) begin
			unique case (cmd.pt)
				PT_START:  fs_q <= acc_q;
				PT_FINISH: ff_q <= acc_q;
				default:   fm_q <= acc_q;
			endcase
		end
		// keep the half whose ends differ in sign
		if (cmd.update) begin
			if (fs_fm_differ) begin
				f_q  <= mid_q;
				ff_q <= fm_q;
			end else begin
				s_q  <= mid_q;
				fs_q <= fm_q;
			end
		end
	end

	assign st.fs_zero   = (fs_q == '0);
	assign st.ff_zero   = (ff_q == '0);
	assign st.fm_zero   = (fm_q == '0);
	assign st.same_sign = (fs_q != '0) && (ff_q != '0) && (fs_q[ACC_W-1] == ff_q[ACC_W-1]);
	assign st.narrow    = $signed({width[POINT_W], width}) < $signed({2'b00, tol_q});
	assign st.out_free  = !out_valid_q || out_ready;

	always_comb begin
		unique case (cmd.res_sel)
			RS_ZERO:   root_d = '0;
			RS_START:  root_d = s_q;
			RS_FINISH: root_d = f_q;
			default:   root_d = mid_q;
		endcase
	end
	assign steps_ext = {{STEPS_OUT_W{1'b0}}, cmd.steps};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			root_point  <= root_d;
			outcome     <= cmd.res_outcome;
			steps_taken <= steps_ext[STEPS_OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

### src/cubic_bisection_root_finder.sv
`timescale 1ns / 1ps
// A search evaluates both ends, then one midpoint per step; it stops on convergence, on an exact zero,
// at the 32-step limit, or with no root when the two ends show no sign change.
// One item is searched at a time, the next taken in the cycle after the result is loaded;
// a cubic is evaluated in three Horner stages, each on one shared 32x24 multiplier
// used twice. A new item is taken while the previous result waits in the output register.
// Reset (arst_n low, asynchronous) clears control, coefficients to 0, tolerance to 655.
module cubic_bisection_root_finder
	import cbrf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [POINT_W-1:0] interval_start,
	input  logic signed [POINT_W-1:0] interval_finish,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [POINT_W-1:0] root_point,
	output logic [OUTCOME_W-1:0]      outcome,
	output logic [STEPS_OUT_W-1:0]    steps_taken,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	cmd_t    cmd;
	status_t st;

	cbrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cbrf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.interval_start  (interval_start),
		.interval_finish (interval_finish),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.root_point      (root_point),
		.outcome         (outcome),
		.steps_taken     (steps_taken),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

endmodule

### src/cbrf_checker.sv
`timescale 1ns / 1ps
module cbrf_checker
	import cbrf_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [POINT_W-1:0] root_point,
	input logic [OUTCOME_W-1:0]      outcome,
	input logic [STEPS_OUT_W-1:0]    steps_taken
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_point)
			&& $stable(outcome) && $stable(steps_taken))
		else $error("result changed while stalled");

	// busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while a search runs");

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_NO_ROOT) |-> (root_point == '0) && (steps_taken == '0))
		else $error("no-root result carries a root or steps");

	a_limit_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_LIMIT) |-> steps_taken == MAX_ITER_OUT)
		else $error("iteration limit reported with wrong step count");

endmodule

bind cubic_bisection_root_finder cbrf_checker u_cbrf_checker (.*);
